[hw/rtl/i2cms_pkg.sv]
package i2cms_pkg;

	localparam int unsigned FifoDepth = 8;

	typedef enum logic [2:0] {
		CMD_START      = 3'd0,
		CMD_STOP       = 3'd1,
		CMD_PROBE      = 3'd2,
		CMD_READ       = 3'd3,
		CMD_WRITE      = 3'd4,
		CMD_WRITE_BYTE = 3'd5,
		CMD_STATUS     = 3'd6,
		CMD_NONE       = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_START = 3'd0,
		ACT_SEND  = 3'd1,
		ACT_ACK   = 3'd2,
		ACT_NACK  = 3'd3,
		ACT_STOP  = 3'd4,
		ACT_DONE  = 3'd5
	} act_t;

	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RSTART      = 8'h10;
	localparam logic [7:0] ST_BUS_IDLE    = 8'hF8;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
	localparam logic [7:0] ADDR_W_MASK    = 8'hFE;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] length;
		logic [7:0]  data_byte;
		logic [7:0]  status_code;
	} req_t;

	typedef struct packed {
		logic        last;
		logic [15:0] done_count;
		logic        ok;
		logic [7:0]  byte_out;
		logic [2:0]  action;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

	function automatic res_t mk_res(act_t act, logic [7:0] b, logic ok, logic [15:0] cnt);
		res_t r;
		r.action     = act;
		r.byte_out   = b;
		r.ok         = ok;
		r.done_count = cnt;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic start_ok(logic [7:0] s);
		return (s == ST_START) || (s == ST_RSTART) || (s == ST_BUS_IDLE);
	endfunction

endpackage

[hw/rtl/i2cms_core.sv]
module i2cms_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  i2cms_pkg::req_t       req,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	output i2cms_pkg::res_pair_t  res
);
	import i2cms_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_START_WAIT  = 4'd1,
		PH_PROBE_START = 4'd2,
		PH_PROBE_ADDR  = 4'd3,
		PH_READ_START  = 4'd4,
		PH_READ_ADDR   = 4'd5,
		PH_READ_DATA   = 4'd6,
		PH_WRITE_READY = 4'd7,
		PH_WRITE_WAIT  = 4'd8
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] bytes_done_q, bytes_done_d;
	logic [7:0]  probe_byte_q, probe_byte_d;
	logic [7:0]  slave_address_q;
	logic [15:0] bl_dec, bd_inc;
	res_pair_t   rp;

	assign bl_dec = bytes_left_q - 16'd1;
	assign bd_inc = bytes_done_q + 16'd1;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		bytes_done_d = bytes_done_q;
		probe_byte_d = probe_byte_q;
		rp           = '0;
		if (go) begin
			case (cmd_t'(req.cmd))
				CMD_STOP: begin
					rp.n    = 2'd2;
					rp.r0   = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0);
					rp.r1   = mk_res(ACT_DONE, 8'd0, 1'b1, 16'd0);
					phase_d = PH_IDLE;
				end
				CMD_STATUS: begin
					case (phase_q)
						PH_START_WAIT: begin
							rp.n    = 2'd1;
							rp.r0   = mk_res(ACT_DONE, 8'd0, start_ok(req.status_code), 16'd0);
							phase_d = PH_IDLE;
						end
						PH_PROBE_START, PH_READ_START: begin
							rp.n = 2'd1;
							if (!start_ok(req.status_code)) begin
								rp.r0   = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0);
								phase_d = PH_IDLE;
							end else if (phase_q == PH_PROBE_START) begin
								rp.r0   = mk_res(ACT_SEND, probe_byte_q & ADDR_W_MASK, 1'b0, 16'd0);
								phase_d = PH_PROBE_ADDR;
							end else begin
								rp.r0   = mk_res(ACT_SEND, slave_address_q | 8'd1, 1'b0, 16'd0);
								phase_d = PH_READ_ADDR;
							end
						end
						PH_PROBE_ADDR: begin
							rp.n    = 2'd2;
							rp.r0   = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0);
							rp.r1   = mk_res(ACT_DONE, 8'd0, req.status_code == ST_SLA_W_ACK,
								16'd0);
							phase_d = PH_IDLE;
						end
						PH_READ_ADDR: begin
							if (req.status_code != ST_SLA_R_ACK || bytes_left_q == 16'd0) begin
								rp.n    = 2'd2;
								rp.r0   = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0);
								rp.r1   = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0);
								phase_d = PH_IDLE;
							end else begin
								rp.n    = 2'd1;
								rp.r0   = mk_res((bytes_left_q == 16'd1) ? ACT_NACK : ACT_ACK,
									8'd0, 1'b0, 16'd0);
								phase_d = PH_READ_DATA;
							end
						end
						PH_READ_DATA: begin
							if (req.status_code != ST_DATA_R_ACK &&
								req.status_code != ST_DATA_R_NACK) begin
								rp.n    = 2'd2;
								rp.r0   = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0);
								rp.r1   = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0);
								phase_d = PH_IDLE;
							end else begin
								bytes_done_d = bd_inc;
								bytes_left_d = bl_dec;
								if (bl_dec == 16'd0) begin
									rp.n    = 2'd2;
									rp.r0   = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0);
									rp.r1   = mk_res(ACT_DONE, 8'd0, 1'b1, bd_inc);
									phase_d = PH_IDLE;
								end else begin
									rp.n  = 2'd1;
									rp.r0 = mk_res((bl_dec == 16'd1) ? ACT_NACK : ACT_ACK,
										8'd0, 1'b0, 16'd0);
								end
							end
						end
						PH_WRITE_WAIT: begin
							if (req.status_code != ST_SLA_W_ACK &&
								req.status_code != ST_DATA_W_ACK) begin
								rp.n    = 2'd2;
								rp.r0   = mk_res(ACT_STOP, 8'd0, 1'b0, 16'd0);
								rp.r1   = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0);
								phase_d = PH_IDLE;
							end else begin
								bytes_done_d = bd_inc;
								bytes_left_d = bl_dec;
								if (bl_dec == 16'd0) begin
									rp.n    = 2'd1;
									rp.r0   = mk_res(ACT_DONE, 8'd0, 1'b1, bd_inc);
									phase_d = PH_IDLE;
								end else begin
									phase_d = PH_WRITE_READY;
								end
							end
						end
						default: ;
					endcase
				end
				CMD_WRITE_BYTE: begin
					if (phase_q == PH_WRITE_READY) begin
						rp.n    = 2'd1;
						rp.r0   = mk_res(ACT_SEND, req.data_byte, 1'b0, 16'd0);
						phase_d = PH_WRITE_WAIT;
					end
				end
				CMD_START, CMD_PROBE, CMD_READ, CMD_WRITE: begin
					if (phase_q == PH_IDLE) begin
						case (cmd_t'(req.cmd))
							CMD_START: begin
								rp.n    = 2'd1;
								rp.r0   = mk_res(ACT_START, 8'd0, 1'b0, 16'd0);
								phase_d = PH_START_WAIT;
							end
							CMD_PROBE: begin
								rp.n         = 2'd1;
								rp.r0        = mk_res(ACT_START, 8'd0, 1'b0, 16'd0);
								probe_byte_d = req.data_byte;
								phase_d      = PH_PROBE_START;
							end
							CMD_READ: begin
								rp.n         = 2'd1;
								rp.r0        = mk_res(ACT_START, 8'd0, 1'b0, 16'd0);
								bytes_left_d = req.length;
								bytes_done_d = 16'd0;
								phase_d      = PH_READ_START;
							end
							default: begin
								bytes_left_d = req.length;
								bytes_done_d = 16'd0;
								if (req.length == 16'd0) begin
									rp.n  = 2'd1;
									rp.r0 = mk_res(ACT_DONE, 8'd0, 1'b0, 16'd0);
								end else begin
									phase_d = PH_WRITE_READY;
								end
							end
						endcase
					end
				end
				default: ;
			endcase
			rp.r0.last = (rp.n == 2'd1);
			rp.r1.last = (rp.n == 2'd2);
		end
	end

	assign res = rp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			bytes_left_q    <= '0;
			bytes_done_q    <= '0;
			probe_byte_q    <= '0;
			slave_address_q <= '0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			bytes_done_q <= bytes_done_d;
			probe_byte_q <= probe_byte_d;
			if (cfg_we) begin
				slave_address_q <= cfg_data;
			end
		end
	end

endmodule

[hw/rtl/i2cms_fifo.sv]
module i2cms_fifo #(
	parameter int unsigned DEPTH = i2cms_pkg::FifoDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cms_pkg::res_pair_t wr,
	output logic                 room2,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output i2cms_pkg::res_t      rd_data
);
	import i2cms_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [CW-1:0] count_q;
	logic          pop;

	assign wr_ptr1  = wr_ptr_q + AW'(1);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;
	assign room2    = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.r0;
		end
		if (wr.n == 2'd2) begin
			mem_q[wr_ptr1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(wr.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(wr.n) - CW'(pop);
		end
	end

endmodule

[hw/rtl/i2c_master_transaction_sequencer.sv]
// I2C master transaction sequencer, sitting above a byte-level I2C engine.
// Slave channel (s_*): one request per transfer, either a software command
// (start, stop, probe, begin read, begin write, write byte) or a status code
// reported by the byte engine. Master channel (m_*): the bus actions to
// perform (start, send byte, ack/nack next, stop) and a final done carrying
// success and the byte count; m_tlast marks the last action of a request.
// A request yields zero, one or two actions.
// cfg_*: slave address byte; the user must write it only while no transaction
// is open, which the block itself does not enforce; cfg_ready is always high.
// A request is registered at the slave side, then decoded and written to the
// output queue once that queue has room for two actions; the master side
// takes its actions from the head of the queue.
// Throughput: one request per cycle while the 8-entry output queue keeps room
// for two actions; two-action requests are limited by the master side's one
// action per cycle.
// Reset clears the phase, counters, address and queue; the block comes up
// idle. When the receiver stalls, actions collect in the queue and s_tready
// drops once it can no longer take the two actions of a further request.
module i2c_master_transaction_sequencer #(
	parameter int unsigned FIFO_DEPTH = i2cms_pkg::FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cmd[2:0], length[18:3], data_byte[26:19], status_code[34:27]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // action[2:0], byte_out[10:3], ok[11], done_count[27:12]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import i2cms_pkg::*;

	logic      valid_s1;
	req_t      req_s1;
	logic      room2;
	logic      go;
	res_pair_t res;
	res_t      head;

	assign go        = valid_s1 && room2;
	assign s_tready  = !valid_s1 || go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cmd         <= s_tdata[2:0];
			req_s1.length      <= s_tdata[18:3];
			req_s1.data_byte   <= s_tdata[26:19];
			req_s1.status_code <= s_tdata[34:27];
		end
	end

	i2cms_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.req      (req_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.res      (res)
	);

	i2cms_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res),
		.room2    (room2),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (head)
	);

	assign m_tdata = {4'd0, head.done_count, head.ok, head.byte_out, head.action};
	assign m_tlast = head.last;

endmodule

[hw/rtl/i2cms_checker.sv]
module i2cms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);
	import i2cms_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_stop_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[2:0] == ACT_STOP |-> !m_tlast)
		else $error("stop must be followed by done");

	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ACT_DONE && !m_tdata[11] |-> m_tdata[27:12] == 16'd0)
		else $error("failing done carries a count");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ACT_DONE |-> m_tlast)
		else $error("done not marked last");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
